@@ rtl/hsl2rgb_pkg.sv @@
// Package: payload types and constants for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

    localparam int HUE_W   = 11;
    localparam int Q12_W   = 13;
    localparam int CH_W    = 8;
    localparam int PQ_W    = 25;
    localparam int FAC_W   = 9;
    localparam int PROD_W  = PQ_W + FAC_W - 1;
    localparam int RAMP_W  = 33;
    localparam int SCALE_W = RAMP_W + 8;

    localparam logic [HUE_W-1:0]   TURN     = 11'd1536;
    localparam logic [HUE_W-1:0]   THIRD    = 11'd512;
    localparam logic [HUE_W-1:0]   SIXTH    = 11'd256;
    localparam logic [Q12_W-1:0]   ONE_Q12  = 13'd4096;
    localparam logic [Q12_W-1:0]   HALF_Q12 = 13'd2048;
    localparam logic [CH_W-1:0]    CH_MAX   = 8'd255;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [Q12_W-1:0] saturation;
        logic [Q12_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

@@ rtl/hsl_to_rgb_converter_top.sv @@
// Top level: four-stage pipelined HSL to 8-bit RGB pixel converter.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------
//  input   | s_valid | s_ready | s_data  (hue, saturation, lightness)
//  result  | m_valid | m_ready | m_data  (red, green, blue)
//
// One pixel enters per cycle unless the output register is full and not taken.
// Stages: clamp and L*S product, p and slope, slope times ramp factor,
// ramp sum and scale by 255 into the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the stage valid bits only; payload registers keep no reset.
`default_nettype none

module hsl_to_rgb_converter_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire hsl2rgb_pkg::hsl_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output hsl2rgb_pkg::rgb_t       m_data
);

    function automatic logic [hsl2rgb_pkg::FAC_W-1:0] ramp_factor(
        input logic [hsl2rgb_pkg::HUE_W-1:0] t
    );
        logic [hsl2rgb_pkg::HUE_W-1:0] fall;
        fall = (hsl2rgb_pkg::SIXTH << 2) - t;
        if (t < hsl2rgb_pkg::SIXTH) begin
            ramp_factor = t[hsl2rgb_pkg::FAC_W-1:0];
        end else if (t < 3 * hsl2rgb_pkg::SIXTH) begin
            ramp_factor = hsl2rgb_pkg::SIXTH[hsl2rgb_pkg::FAC_W-1:0];
        end else if (t < 4 * hsl2rgb_pkg::SIXTH) begin
            ramp_factor = fall[hsl2rgb_pkg::FAC_W-1:0];
        end else begin
            ramp_factor = '0;
        end
    endfunction

    function automatic logic [hsl2rgb_pkg::CH_W-1:0] scale_channel(
        input logic [hsl2rgb_pkg::PQ_W-1:0]   p,
        input logic [hsl2rgb_pkg::PROD_W-1:0] prod
    );
        logic [hsl2rgb_pkg::RAMP_W-1:0]  ramp;
        logic [hsl2rgb_pkg::SCALE_W-1:0] scaled;
        logic [hsl2rgb_pkg::SCALE_W-33:0] top;
        ramp   = {p, 8'b0} + prod;
        scaled = {ramp, 8'b0} - {8'b0, ramp};
        top    = scaled[hsl2rgb_pkg::SCALE_W-1:32];
        if (top > {1'b0, hsl2rgb_pkg::CH_MAX}) begin
            scale_channel = hsl2rgb_pkg::CH_MAX;
        end else begin
            scale_channel = top[hsl2rgb_pkg::CH_W-1:0];
        end
    endfunction

    logic advance;

    // stage 1
    logic                            s1_valid_reg;
    logic [hsl2rgb_pkg::HUE_W-1:0]   s1_tg_reg, s1_tr_reg, s1_tb_reg;
    logic [hsl2rgb_pkg::Q12_W-1:0]   s1_sat_reg, s1_light_reg;
    logic [hsl2rgb_pkg::PQ_W-1:0]    s1_ls_reg;
    logic [hsl2rgb_pkg::HUE_W-1:0]   hue_next, tr_next, tb_next;
    logic [hsl2rgb_pkg::HUE_W:0]     tr_sum, tb_sum;
    logic [hsl2rgb_pkg::Q12_W-1:0]   sat_next, light_next;
    logic [2*hsl2rgb_pkg::Q12_W-1:0] ls_full;

    // stage 2
    logic                            s2_valid_reg;
    logic [hsl2rgb_pkg::PQ_W-1:0]    s2_p_reg, s2_d_reg;
    logic [hsl2rgb_pkg::FAC_W-1:0]   s2_fr_reg, s2_fg_reg, s2_fb_reg;
    logic [hsl2rgb_pkg::PQ_W:0]      l12, s12, ls_ext, p_next, d_next;

    // stage 3
    logic                            s3_valid_reg;
    logic [hsl2rgb_pkg::PQ_W-1:0]    s3_p_reg;
    logic [hsl2rgb_pkg::PROD_W-1:0]  s3_pr_reg, s3_pg_reg, s3_pb_reg;
    logic [hsl2rgb_pkg::PQ_W+hsl2rgb_pkg::FAC_W-1:0] pr_full, pg_full, pb_full;

    // stage 4 / output
    logic                            out_valid_reg;
    hsl2rgb_pkg::rgb_t               out_data_reg;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        hue_next = (s_data.hue >= hsl2rgb_pkg::TURN) ?
                   s_data.hue - hsl2rgb_pkg::TURN : s_data.hue;
        tr_sum   = {1'b0, hue_next} + {1'b0, hsl2rgb_pkg::THIRD};
        tb_sum   = {1'b0, hue_next} + {1'b0, hsl2rgb_pkg::TURN - hsl2rgb_pkg::THIRD};
        tr_next  = (tr_sum >= {1'b0, hsl2rgb_pkg::TURN}) ?
                   hsl2rgb_pkg::HUE_W'(tr_sum - {1'b0, hsl2rgb_pkg::TURN}) :
                   tr_sum[hsl2rgb_pkg::HUE_W-1:0];
        tb_next  = (tb_sum >= {1'b0, hsl2rgb_pkg::TURN}) ?
                   hsl2rgb_pkg::HUE_W'(tb_sum - {1'b0, hsl2rgb_pkg::TURN}) :
                   tb_sum[hsl2rgb_pkg::HUE_W-1:0];
        sat_next   = (s_data.saturation > hsl2rgb_pkg::ONE_Q12) ?
                     hsl2rgb_pkg::ONE_Q12 : s_data.saturation;
        light_next = (s_data.lightness > hsl2rgb_pkg::ONE_Q12) ?
                     hsl2rgb_pkg::ONE_Q12 : s_data.lightness;
        ls_full    = sat_next * light_next;
    end

    always_comb begin
        l12    = {1'b0, s1_light_reg, 12'b0};
        s12    = {1'b0, s1_sat_reg, 12'b0};
        ls_ext = {1'b0, s1_ls_reg};
        if (s1_light_reg < hsl2rgb_pkg::HALF_Q12) begin
            p_next = l12 - ls_ext;
            d_next = {ls_ext[hsl2rgb_pkg::PQ_W-1:0], 1'b0};
        end else begin
            p_next = l12 + ls_ext - s12;
            d_next = (s12 - ls_ext) << 1;
        end
    end

    always_comb begin
        pr_full = s2_d_reg * s2_fr_reg;
        pg_full = s2_d_reg * s2_fg_reg;
        pb_full = s2_d_reg * s2_fb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= s_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_tg_reg    <= hue_next;
            s1_tr_reg    <= tr_next;
            s1_tb_reg    <= tb_next;
            s1_sat_reg   <= sat_next;
            s1_light_reg <= light_next;
            s1_ls_reg    <= ls_full[hsl2rgb_pkg::PQ_W-1:0];

            s2_p_reg  <= p_next[hsl2rgb_pkg::PQ_W-1:0];
            s2_d_reg  <= d_next[hsl2rgb_pkg::PQ_W-1:0];
            s2_fr_reg <= ramp_factor(s1_tr_reg);
            s2_fg_reg <= ramp_factor(s1_tg_reg);
            s2_fb_reg <= ramp_factor(s1_tb_reg);

            s3_p_reg  <= s2_p_reg;
            s3_pr_reg <= pr_full[hsl2rgb_pkg::PROD_W-1:0];
            s3_pg_reg <= pg_full[hsl2rgb_pkg::PROD_W-1:0];
            s3_pb_reg <= pb_full[hsl2rgb_pkg::PROD_W-1:0];

            out_data_reg.red   <= scale_channel(s3_p_reg, s3_pr_reg);
            out_data_reg.green <= scale_channel(s3_p_reg, s3_pg_reg);
            out_data_reg.blue  <= scale_channel(s3_p_reg, s3_pb_reg);
        end
    end

endmodule

`default_nettype wire

@@ test/hsl_to_rgb_converter_top_test.sv @@
// Testbench for the HSL to RGB converter: random and directed pixels checked against a predictor.
`timescale 1ns / 100ps

module hsl_to_rgb_converter_top_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_PIXELS  = 180;
    localparam int DRAIN_CYCLES  = 8;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hsl2rgb_pkg::hsl_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hsl2rgb_pkg::rgb_t m_data;

    hsl2rgb_pkg::hsl_t pending_pixels[$];
    hsl2rgb_pkg::rgb_t expected_rgb[$];
    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors = 0;
    int   pixels_sent = 0;
    int   pixels_checked = 0;
    int   directed_count = 0;
    int   stall_cycles = 0;

    hsl_to_rgb_converter_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [hsl2rgb_pkg::CH_W-1:0] ramp_level(logic [63:0] p24,
                                                                logic [63:0] q24,
                                                                logic [11:0] pos);
        logic [63:0] t = 64'(pos);
        logic [63:0] six = 64'(hsl2rgb_pkg::SIXTH);
        logic [63:0] lvl;
        logic [63:0] scaled;
        if (t < six) begin
            lvl = p24 * six + (q24 - p24) * t;
        end else if (t < 3 * six) begin
            lvl = q24 * six;
        end else if (t < 4 * six) begin
            lvl = p24 * six + (q24 - p24) * (4 * six - t);
        end else begin
            lvl = p24 * six;
        end
        scaled = (lvl * 64'd255) >> 32;
        if (scaled > 64'(hsl2rgb_pkg::CH_MAX)) begin
            scaled = 64'(hsl2rgb_pkg::CH_MAX);
        end
        return scaled[hsl2rgb_pkg::CH_W-1:0];
    endfunction

    function automatic hsl2rgb_pkg::rgb_t predict_rgb(hsl2rgb_pkg::hsl_t px);
        logic [11:0] hue = 12'(px.hue);
        logic [11:0] turn = 12'(hsl2rgb_pkg::TURN);
        logic [11:0] pos_r;
        logic [11:0] pos_b;
        logic [63:0] sat;
        logic [63:0] light;
        logic [63:0] one = 64'(hsl2rgb_pkg::ONE_Q12);
        logic [63:0] q24;
        logic [63:0] p24;
        hsl2rgb_pkg::rgb_t px_out;
        if (hue >= turn) begin
            hue = hue - turn;
        end
        sat   = (px.saturation > hsl2rgb_pkg::ONE_Q12) ? one : 64'(px.saturation);
        light = (px.lightness > hsl2rgb_pkg::ONE_Q12) ? one : 64'(px.lightness);
        if (light < 64'(hsl2rgb_pkg::HALF_Q12)) begin
            q24 = light * (one + sat);
        end else begin
            q24 = (light + sat) * one - light * sat;
        end
        p24 = 2 * light * one - q24;
        pos_r = hue + 12'(hsl2rgb_pkg::THIRD);
        if (pos_r >= turn) begin
            pos_r = pos_r - turn;
        end
        pos_b = hue + (turn - 12'(hsl2rgb_pkg::THIRD));
        if (pos_b >= turn) begin
            pos_b = pos_b - turn;
        end
        px_out.red   = ramp_level(p24, q24, pos_r);
        px_out.green = ramp_level(p24, q24, hue);
        px_out.blue  = ramp_level(p24, q24, pos_b);
        return px_out;
    endfunction

    function automatic logic [hsl2rgb_pkg::Q12_W-1:0] rand_q12(
        logic [hsl2rgb_pkg::Q12_W-1:0] edge_val
    );
        int pick = $urandom_range(99);
        if (pick < 8) begin
            return '0;
        end else if (pick < 16) begin
            return hsl2rgb_pkg::ONE_Q12;
        end else if (pick < 26) begin
            return hsl2rgb_pkg::Q12_W'($urandom_range(8191));
        end else if (pick < 34) begin
            return edge_val + hsl2rgb_pkg::Q12_W'($urandom_range(1));
        end
        return hsl2rgb_pkg::Q12_W'($urandom_range(4096));
    endfunction

    function automatic hsl2rgb_pkg::hsl_t rand_pixel();
        hsl2rgb_pkg::hsl_t px;
        if ($urandom_range(99) < 85) begin
            px.hue = hsl2rgb_pkg::HUE_W'($urandom_range(1535));
        end else begin
            px.hue = hsl2rgb_pkg::HUE_W'($urandom_range(2047));
        end
        px.saturation = rand_q12(hsl2rgb_pkg::ONE_Q12 - 13'd1);
        px.lightness  = rand_q12(hsl2rgb_pkg::HALF_Q12 - 13'd1);
        return px;
    endfunction

    task automatic add_pixel(int hue, int sat, int light);
        hsl2rgb_pkg::hsl_t px;
        px.hue        = hsl2rgb_pkg::HUE_W'(hue);
        px.saturation = hsl2rgb_pkg::Q12_W'(sat);
        px.lightness  = hsl2rgb_pkg::Q12_W'(light);
        pending_pixels.push_back(px);
    endtask

    task automatic check_channel(string chan, logic [hsl2rgb_pkg::CH_W-1:0] want,
                                 logic [hsl2rgb_pkg::CH_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_pixels.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : monitor
        hsl2rgb_pkg::rgb_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rgb.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got %h", $time, m_data);
                end else begin
                    want = expected_rgb.pop_front();
                    check_channel("red", want.red, m_data.red);
                    check_channel("green", want.green, m_data.green);
                    check_channel("blue", want.blue, m_data.blue);
                    pixels_checked++;
                end
            end
            if (s_valid && s_ready) begin
                expected_rgb.push_back(predict_rgb(s_data));
                pixels_sent++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 63;

        add_pixel(0, 4096, 2048);
        add_pixel(255, 4096, 2048);
        add_pixel(256, 4096, 2048);
        add_pixel(511, 4096, 2048);
        add_pixel(512, 4096, 2048);
        add_pixel(767, 4096, 2048);
        add_pixel(768, 4096, 2048);
        add_pixel(1023, 4096, 2048);
        add_pixel(1024, 4096, 2048);
        add_pixel(1535, 4096, 2048);
        add_pixel(700, 0, 0);
        add_pixel(700, 0, 4096);
        add_pixel(700, 0, 1234);
        add_pixel(1536, 4096, 2048);
        add_pixel(2047, 3000, 1500);
        add_pixel(100, 8191, 2048);
        add_pixel(900, 2000, 8191);
        add_pixel(2047, 8191, 8191);
        add_pixel(300, 2500, 2047);
        add_pixel(300, 2500, 2048);
        add_pixel(1200, 4096, 4096);
        add_pixel(1200, 4096, 0);
        add_pixel(0, 1, 1);
        add_pixel(400, 4095, 4095);
        directed_count = pending_pixels.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 63;
                recv_idle_pct = 11;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                pending_pixels.push_back(rand_pixel());
            end
            while (pending_pixels.size() != 0) begin
                @(posedge aclk);
            end
        end

        while (s_valid || expected_rgb.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d pixels (%0d directed) and checked %0d results;", pixels_sent,
                 directed_count, pixels_checked);
        $display("covered sextant edges, grey, hue wrap and clamped inputs, three stall mixes.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hsl2rgb_pkg.sv
rtl/hsl_to_rgb_converter_top.sv
test/hsl_to_rgb_converter_top_test.sv
